FILE: rtl/mbps_pkg.sv
// ----------------------------------------------------------------------------
// mbps_pkg
// shared constants, types and helpers of the masked byte pattern scanner
// ----------------------------------------------------------------------------
package mbps_pkg;

    localparam int PATTERN_MAX = 16;
    localparam int IDX_W       = $clog2(PATTERN_MAX);
    localparam int LEN_W       = 5;
    localparam int CFG_IDX_W   = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PAT_LO    = 3'd0,
        CFG_PAT_HI    = 3'd1,
        CFG_CARE      = 3'd2,
        CFG_LENGTH    = 3'd3,
        CFG_INSTANCE  = 3'd4,
        CFG_BASE      = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic [63:0]      pat_lo;
        logic [63:0]      pat_hi;
        logic [15:0]      care;
        logic [LEN_W-1:0] length;
        logic [15:0]      instance_wanted;
        logic [63:0]      base;
    } cfg_t;

    // length zero acts as one, anything above the cell count is clipped
    function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] len);
        logic [LEN_W-1:0] r;
        r = len;
        if (len == '0)
            r = LEN_W'(1);
        if (len > LEN_W'(PATTERN_MAX))
            r = LEN_W'(PATTERN_MAX);
        return r;
    endfunction

endpackage

FILE: rtl/mbps_cfg_regs.sv
// ----------------------------------------------------------------------------
// mbps_cfg_regs
// configuration register file, written through its own valid/ready channel
// ----------------------------------------------------------------------------
module mbps_cfg_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [mbps_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]                   cfg_data,
    output mbps_pkg::cfg_t                cfg
);
    import mbps_pkg::*;

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg         = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pat_lo          <= '0;
            cfg_reg.pat_hi          <= '0;
            cfg_reg.care            <= 16'hFFFF;
            cfg_reg.length          <= LEN_W'(1);
            cfg_reg.instance_wanted <= '0;
            cfg_reg.base            <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_PAT_LO:   cfg_reg.pat_lo          <= cfg_data;
                CFG_PAT_HI:   cfg_reg.pat_hi          <= cfg_data;
                CFG_CARE:     cfg_reg.care            <= cfg_data[15:0];
                CFG_LENGTH:   cfg_reg.length          <= cfg_data[LEN_W-1:0];
                CFG_INSTANCE: cfg_reg.instance_wanted <= cfg_data[15:0];
                CFG_BASE:     cfg_reg.base            <= cfg_data;
                default:      ;
            endcase
        end
    end

endmodule

FILE: rtl/mbps_cell.sv
// ----------------------------------------------------------------------------
// mbps_cell
// one window byte: shifts in from its neighbor and compares the incoming byte
// ----------------------------------------------------------------------------
module mbps_cell (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       shift_en,
    input  logic       clear,
    input  logic [7:0] shift_in,
    input  logic [7:0] pat_byte,
    input  logic       care_bit,
    input  logic       active,
    output logic [7:0] byte_out,
    output logic       hit
);
    logic [7:0] byte_reg;
    logic [7:0] byte_next;

    // hit looks at the value this cell holds after the shift
    assign hit      = !active || !care_bit || (shift_in == pat_byte);
    assign byte_out = byte_reg;

    always_comb
    begin
        byte_next = byte_reg;
        if (clear)
            byte_next = '0;
        else if (shift_en)
            byte_next = shift_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            byte_reg <= '0;
        else
            byte_reg <= byte_next;
    end

endmodule

FILE: rtl/masked_byte_pattern_scanner.sv
// ----------------------------------------------------------------------------
// masked_byte_pattern_scanner
// wildcard byte pattern search over a streamed region, reports the nth match
// ----------------------------------------------------------------------------
// the result of a byte is registered and shows in the cycle after its transfer
// throughput: one byte per cycle while no result waits; the whole window
//   compare over the cell row and the address add settle as the byte is taken
// reset: rst_n clears window, counters and output valid at once; all but
//   found and match_address return to defaults, no clearing pass is needed
module masked_byte_pattern_scanner (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [7:0]                     data_byte,
    input  logic                           last_byte,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           found,
    output logic [63:0]                    match_address,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [mbps_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]                    cfg_data
);
    import mbps_pkg::*;

    cfg_t             cfg;
    logic [LEN_W-1:0] len;
    logic             in_xfer;
    logic             shift_en;

    logic [7:0]             chain [PATTERN_MAX+1];
    logic [PATTERN_MAX-1:0] cell_hit;
    logic [8*PATTERN_MAX-1:0] pat_all;

    logic [63:0] bytes_seen_reg, bytes_seen_next, bytes_inc;
    logic [15:0] matches_reg, matches_next;
    logic        done_reg, done_next;
    logic        out_valid_reg, out_valid_next;
    logic        found_reg, found_next;
    logic [63:0] addr_reg, addr_next;
    logic        match;
    logic        res_now;

    mbps_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    assign len      = eff_len(cfg.length);
    assign pat_all  = {cfg.pat_hi, cfg.pat_lo}[8*PATTERN_MAX-1:0];
    assign in_ready = !out_valid_reg || out_ready;
    assign in_xfer  = in_valid && in_ready;
    assign shift_en = in_xfer && !done_reg;

    assign chain[0] = data_byte;

    // cell k holds the byte k steps old and checks pattern position len-1-k
    for (genvar k = 0; k < PATTERN_MAX; k++)
    begin : g_cell
        logic [LEN_W-1:0] pos;
        logic [IDX_W-1:0] pidx;
        assign pos  = LEN_W'(len - LEN_W'(1) - LEN_W'(k));
        assign pidx = pos[IDX_W-1:0];

        mbps_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .shift_en (shift_en),
            .clear    (in_xfer && last_byte),
            .shift_in (chain[k]),
            .pat_byte (pat_all[8*pidx +: 8]),
            .care_bit (cfg.care[pidx]),
            .active   (LEN_W'(k) < len),
            .byte_out (chain[k+1]),
            .hit      (cell_hit[k])
        );
    end

    assign bytes_inc = (bytes_seen_reg == '1) ? bytes_seen_reg : bytes_seen_reg + 64'd1;
    assign match     = (&cell_hit) && (bytes_inc >= 64'(len));

    always_comb
    begin
        bytes_seen_next = bytes_seen_reg;
        matches_next    = matches_reg;
        done_next       = done_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        found_next      = found_reg;
        addr_next       = addr_reg;
        res_now         = 1'b0;
        if (shift_en)
        begin
            bytes_seen_next = bytes_inc;
            if (match)
            begin
                if (matches_reg == cfg.instance_wanted)
                begin
                    res_now        = 1'b1;
                    done_next      = 1'b1;
                    out_valid_next = 1'b1;
                    found_next     = 1'b1;
                    addr_next      = cfg.base + bytes_inc - 64'(len);
                end
                else if (matches_reg != 16'hFFFF)
                begin
                    matches_next = matches_reg + 16'd1;
                end
            end
            if (last_byte && !res_now)
            begin
                out_valid_next = 1'b1;
                found_next     = 1'b0;
                addr_next      = '0;
            end
        end
        if (in_xfer && last_byte)
        begin
            bytes_seen_next = '0;
            matches_next    = '0;
            done_next       = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_seen_reg <= '0;
            matches_reg    <= '0;
            done_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            bytes_seen_reg <= bytes_seen_next;
            matches_reg    <= matches_next;
            done_reg       <= done_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        found_reg <= found_next;
        addr_reg  <= addr_next;
    end

    assign out_valid     = out_valid_reg;
    assign found         = found_reg;
    assign match_address = addr_reg;

endmodule

FILE: rtl/mbps_checker.sv
// ----------------------------------------------------------------------------
// mbps_assert
// port-level checks of the scanner, bound to the top level
// ----------------------------------------------------------------------------
module mbps_assert (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic        found,
    input logic [63:0] match_address
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(found) && $stable(match_address))
        else $error("result changed while stalled");

    // not-found always carries address zero
    a_nf_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found |-> match_address == 64'd0)
        else $error("not-found result with nonzero address");

    // input stalls while a result waits
    a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input taken while result waits");

    a_no_idle_result: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid && !(in_valid && in_ready) |=> !out_valid)
        else $error("result without an input transfer");

endmodule

bind masked_byte_pattern_scanner mbps_assert u_mbps_assert (.*);

FILE: sim/mbps_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mbps_checker
// watches the byte, result and register channels of the masked byte pattern
// scanner, predicts every result from its own copy of the registers and the
// scan state, and compares each result transfer with the oldest prediction
// ----------------------------------------------------------------------------
module mbps_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           in_ready,
    input  logic [7:0]                     data_byte,
    input  logic                           last_byte,
    input  logic                           out_valid,
    input  logic                           out_ready,
    input  logic                           found,
    input  logic [63:0]                    match_address,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [mbps_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]                    cfg_data,
    output int                             fail_count,
    output int                             pending,
    output int                             results_seen
);
    import mbps_pkg::*;

    localparam int WIN = PATTERN_MAX;

    typedef struct packed {
        logic        found;
        logic [63:0] addr;
    } scan_result_t;

    scan_result_t expected_q[$];

    cfg_t        regs;
    logic [7:0]  window [WIN];      // window[0] is the newest byte
    logic [63:0] bytes_seen;
    logic [15:0] matches_counted;
    logic        search_done;

    function automatic int clip_len(input logic [LEN_W-1:0] len);
        if (len == '0)
            return 1;
        if (int'(len) > WIN)
            return WIN;
        return int'(len);
    endfunction

    task automatic clear_region();
        for (int k = 0; k < WIN; k++)
            window[k] = 8'h00;
        bytes_seen      = '0;
        matches_counted = '0;
        search_done     = 1'b0;
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] value);
        case (idx)
            CFG_PAT_LO:   regs.pat_lo          = value;
            CFG_PAT_HI:   regs.pat_hi          = value;
            CFG_CARE:     regs.care            = value[15:0];
            CFG_LENGTH:   regs.length          = value[LEN_W-1:0];
            CFG_INSTANCE: regs.instance_wanted = value[15:0];
            CFG_BASE:     regs.base            = value;
            default:      ;
        endcase
    endtask

    task automatic scan_byte(input logic [7:0] b, input logic last);
        int           n;
        bit           hit;
        bit           given;
        logic [127:0] pattern;
        scan_result_t r;
        given = 1'b0;
        if (!search_done)
        begin
            n       = clip_len(regs.length);
            pattern = {regs.pat_hi, regs.pat_lo};
            for (int k = WIN - 1; k > 0; k--)
                window[k] = window[k-1];
            window[0] = b;
            if (bytes_seen != '1)
                bytes_seen = bytes_seen + 64'd1;
            if (bytes_seen >= 64'(n))
            begin
                hit = 1'b1;
                // oldest window byte lines up with pattern byte 0
                for (int i = 0; i < n; i++)
                    if (regs.care[i] && window[n-1-i] != pattern[i*8 +: 8])
                        hit = 1'b0;
                if (hit)
                begin
                    if (matches_counted == regs.instance_wanted)
                    begin
                        r.found = 1'b1;
                        r.addr  = regs.base + (bytes_seen - 64'(n));
                        expected_q = {expected_q, r};
                        given       = 1'b1;
                        search_done = 1'b1;
                    end
                    else if (matches_counted != 16'hFFFF)
                    begin
                        matches_counted = matches_counted + 16'd1;
                    end
                end
            end
            if (last && !given)
            begin
                r.found = 1'b0;
                r.addr  = '0;
                expected_q = {expected_q, r};
            end
        end
        if (last)
            clear_region();
    endtask

    task automatic check_result(input logic got_found, input logic [63:0] got_addr);
        scan_result_t want;
        results_seen++;
        if (expected_q.size() == 0)
        begin
            fail_count++;
            if (fail_count <= 10)
                $display("%0t: unexpected result transfer: found=%0b match_address=%h",
                         $time, got_found, got_addr);
        end
        else
        begin
            want = expected_q.pop_front();
            if (got_found !== want.found || got_addr !== want.addr)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("%0t: result %0d mismatch: expected found=%0b match_address=%h, %s",
                             $time, results_seen, want.found, want.addr,
                             $sformatf("got found=%0b match_address=%h", got_found, got_addr));
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs.pat_lo          = '0;
            regs.pat_hi          = '0;
            regs.care            = 16'hFFFF;
            regs.length          = LEN_W'(1);
            regs.instance_wanted = '0;
            regs.base            = '0;
            clear_region();
            expected_q.delete();
            fail_count   = 0;
            results_seen = 0;
            pending      = 0;
        end
        else
        begin
            if (out_valid && out_ready)
                check_result(found, match_address);
            // a register write lands after a byte taken on the same edge
            if (in_valid && in_ready)
                scan_byte(data_byte, last_byte);
            if (cfg_valid && cfg_ready)
                write_register(cfg_index, cfg_data);
            pending = expected_q.size();
        end
    end

endmodule

FILE: sim/tb_masked_byte_pattern_scanner.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_masked_byte_pattern_scanner
// drives regions of bytes and register settings into the scanner with random
// gaps and result stalls; the checker beside the block predicts and compares
// ----------------------------------------------------------------------------
module tb_masked_byte_pattern_scanner;
    import mbps_pkg::*;

    localparam int CYCLE_LIMIT  = 1_500_000;
    localparam int RANDOM_ITEMS = 1050;
    localparam int LONG_REGION  = 256;
    localparam int SETTLE_WAIT  = 3;

    localparam logic [CFG_IDX_W-1:0] IDX_UNUSED_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] IDX_UNUSED_B = 3'd7;

    logic                 clk           = 1'b0;
    logic                 rst_n         = 1'b0;
    logic                 in_valid      = 1'b0;
    logic                 in_ready;
    logic [7:0]           data_byte     = 8'h00;
    logic                 last_byte     = 1'b0;
    logic                 out_valid;
    logic                 out_ready     = 1'b0;
    logic                 found;
    logic [63:0]          match_address;
    logic                 cfg_valid     = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index     = '0;
    logic [63:0]          cfg_data      = '0;

    int fail_count;
    int pending;
    int results_seen;

    cfg_t       plan;
    logic [7:0] region_q[$];
    bit         tx_gaps_on   = 1'b1;
    bit         rx_stalls_on = 1'b1;
    int         rx_hold      = 0;
    int         bytes_sent   = 0;
    int         regions_sent = 0;
    int         writes_done  = 0;

    masked_byte_pattern_scanner u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .data_byte     (data_byte),
        .last_byte     (last_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .found         (found),
        .match_address (match_address),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    mbps_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .data_byte     (data_byte),
        .last_byte     (last_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .found         (found),
        .match_address (match_address),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .pending       (pending),
        .results_seen  (results_seen)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("timeout after %0d cycles", CYCLE_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 8);
        return $urandom_range(20, 60);
    endfunction

    function automatic int clip_len(input logic [LEN_W-1:0] len);
        if (len == '0)
            return 1;
        if (int'(len) > PATTERN_MAX)
            return PATTERN_MAX;
        return int'(len);
    endfunction

    // result side stalls
    always @(posedge clk)
    begin
        if (!rx_stalls_on)
        begin
            out_ready <= 1'b1;
        end
        else if (rx_hold > 0)
        begin
            rx_hold <= rx_hold - 1;
        end
        else if ($urandom_range(0, 2) == 0)
        begin
            out_ready <= 1'b0;
            rx_hold   <= pick_gap();
        end
        else
        begin
            out_ready <= 1'b1;
            rx_hold   <= $urandom_range(0, 4);
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = tx_gaps_on ? pick_gap() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        last_byte <= last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_region();
        foreach (region_q[i])
            send_byte(region_q[i], i == region_q.size() - 1);
        regions_sent++;
    endtask

    // hold the byte side until every predicted result has been taken
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_WAIT) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        writes_done++;
        @(posedge clk);
    endtask

    // narrow registers get junk in the unused upper data bits
    task automatic apply_plan();
        write_reg(CFG_PAT_LO, plan.pat_lo);
        write_reg(CFG_PAT_HI, plan.pat_hi);
        write_reg(CFG_CARE, {$urandom, 16'($urandom), plan.care});
        if ($urandom_range(0, 3) == 0)
            write_reg($urandom_range(0, 1) ? IDX_UNUSED_A : IDX_UNUSED_B, {$urandom, $urandom});
        write_reg(CFG_LENGTH, {$urandom, 27'($urandom), plan.length});
        write_reg(CFG_INSTANCE, {$urandom, 16'($urandom), plan.instance_wanted});
        write_reg(CFG_BASE, plan.base);
    endtask

    task automatic randomize_plan();
        plan.pat_lo = {$urandom, $urandom};
        plan.pat_hi = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0:       plan.length = '0;
            1:       plan.length = LEN_W'($urandom_range(17, 31));
            2, 3:    plan.length = LEN_W'($urandom_range(7, 16));
            default: plan.length = LEN_W'($urandom_range(1, 6));
        endcase
        case ($urandom_range(0, 3))
            0, 1:    plan.care = 16'hFFFF;
            2:       plan.care = 16'($urandom);
            default: plan.care = ~(16'h0001 << $urandom_range(0, 15));
        endcase
        case ($urandom_range(0, 19))
            0:       plan.instance_wanted = 16'hFFFF;
            1, 2:    plan.instance_wanted = 16'($urandom_range(4, 65535));
            default: plan.instance_wanted = 16'($urandom_range(0, 3));
        endcase
        if ($urandom_range(0, 4) == 0)
            plan.base = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 64));
        else
            plan.base = {$urandom, $urandom};
    endtask

    // noise drawn mostly from the pattern bytes, with whole and cut-short
    // copies of the pattern dropped in at random places
    task automatic build_region();
        int           eff;
        int           rlen;
        int           pos;
        int           cut;
        int           pick;
        logic [127:0] pat;
        region_q.delete();
        pat  = {plan.pat_hi, plan.pat_lo};
        eff  = clip_len(plan.length);
        rlen = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                           : $urandom_range(1, 3 * eff + 8);
        for (int i = 0; i < rlen; i++)
        begin
            pick = $urandom_range(0, eff - 1);
            if ($urandom_range(0, 4) < 3)
                region_q = {region_q, pat[pick*8 +: 8]};
            else
                region_q = {region_q, 8'($urandom)};
        end
        repeat ($urandom_range(0, 4))
        begin
            pos = $urandom_range(0, rlen - 1);
            cut = ($urandom_range(0, 4) == 0) ? $urandom_range(1, eff) : eff;
            for (int i = 0; i < cut && pos + i < rlen; i++)
                if (plan.care[i])
                    region_q[pos+i] = pat[i*8 +: 8];
        end
    endtask

    initial
    begin
        logic [127:0] pat;
        int           random_bytes;
        random_bytes         = 0;
        plan.pat_lo          = '0;
        plan.pat_hi          = '0;
        plan.care            = 16'hFFFF;
        plan.length          = LEN_W'(1);
        plan.instance_wanted = '0;
        plan.base            = '0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: single zero byte, match on the last byte
        region_q = {8'h00};
        send_region();
        region_q = {8'hFF, 8'h00};
        send_region();

        // length zero, top base so the address wraps, bytes after the report
        settle();
        plan.pat_lo = 64'h0000_0000_0000_00A5;
        plan.length = '0;
        plan.base   = 64'hFFFF_FFFF_FFFF_FFFF;
        apply_plan();
        write_reg(IDX_UNUSED_A, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(IDX_UNUSED_B, 64'hFFFF_FFFF_FFFF_FFFF);
        region_q = {8'h11, 8'hA5, 8'hA5, 8'h22};
        send_region();

        // oversized length clips to the full window, region too short
        settle();
        plan.length = LEN_W'(31);
        apply_plan();
        region_q = {8'hA5, 8'hA5};
        send_region();

        // full sixteen byte pattern with wildcards at both ends
        settle();
        plan.pat_lo = 64'hFEDC_BA98_7654_3210;
        plan.pat_hi = 64'h0F1E_2D3C_4B5A_6978;
        plan.care   = 16'h7FFE;
        plan.length = LEN_W'(16);
        plan.base   = 64'h8000_0000_0000_0000;
        apply_plan();
        pat = {plan.pat_hi, plan.pat_lo};
        region_q.delete();
        for (int i = 0; i < PATTERN_MAX; i++)
            region_q = {region_q, (plan.care[i] ? pat[i*8 +: 8] : ~pat[i*8 +: 8])};
        send_region();

        // every byte matches: the wanted instance falls on the last byte
        settle();
        plan.care            = 16'h0000;
        plan.length          = LEN_W'(1);
        plan.instance_wanted = 16'(LONG_REGION - 1);
        plan.base            = {$urandom, $urandom};
        apply_plan();
        tx_gaps_on = 1'b0;
        for (int i = 0; i < LONG_REGION; i++)
            send_byte(8'($urandom), i == LONG_REGION - 1);
        regions_sent++;

        while (random_bytes < RANDOM_ITEMS)
        begin
            if (regions_sent % 3 == 0)
            begin
                settle();
                randomize_plan();
                apply_plan();
            end
            tx_gaps_on   = $urandom_range(0, 3) != 0;
            rx_stalls_on = $urandom_range(0, 3) != 0;
            build_region();
            random_bytes += region_q.size();
            send_region();
        end

        settle();
        repeat (10) @(posedge clk);
        $display("sent %0d bytes in %0d regions with %0d register writes",
                 bytes_sent, regions_sent, writes_done);
        $display("checked %0d results, %0d failures", results_seen, fail_count);
        if (fail_count == 0 && pending == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
